/* rtl/escaped_frame_decoder_defines.svh */
// Assertion macros for the escaped frame decoder.
// Each macro checks on the rising edge of clk and is quiet while rst_n is low.
`ifndef ESCAPED_FRAME_DECODER_DEFINES_SVH
`define ESCAPED_FRAME_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define EFD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define EFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EFD_ASSERT_IMPL(label, ante, cons, msg)
`define EFD_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* rtl/efd_pkg.sv */
`default_nettype none

package efd_pkg;

    localparam int BYTE_W         = 8;
    localparam int TYPE_W         = 3;
    localparam int TCNT_W         = 4;
    localparam int STATUS_W       = 2;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;
    localparam int FRAME_OVERHEAD = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_SYMBOL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_MASK     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PARAM_MASK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_COUNT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_SIZES = 3'd4;

    // Register reset values
    localparam logic [BYTE_W-1:0]     RST_START_SYMBOL  = 8'd126;
    localparam logic [BYTE_W-1:0]     RST_TYPE_MASK     = 8'd7;
    localparam logic [BYTE_W-1:0]     RST_PARAM_MASK    = 8'd248;
    localparam logic [TCNT_W-1:0]     RST_TYPE_COUNT    = 4'd8;
    localparam logic [CFG_DATA_W-1:0] RST_PAYLOAD_SIZES = 64'd0;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_GOOD     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CHECKSUM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0]     start_symbol;
        logic [BYTE_W-1:0]     type_mask;
        logic [BYTE_W-1:0]     param_mask;
        logic [TCNT_W-1:0]     type_count;
        logic [CFG_DATA_W-1:0] payload_sizes;
    } cfg_t;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_START,
        PH_DATA
    } phase_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_EVAL,
        CS_EMIT_RD,
        CS_EMIT_LD
    } ctrl_state_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_STATUS,
        ACT_BURST
    } act_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
        logic load_status;
        logic emit_step;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        act_t action;
        logic out_free;
        logic burst_last;
    } stat_t;

endpackage

`default_nettype wire

/* rtl/efd_cfg.sv */
`default_nettype none

module efd_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [efd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [efd_pkg::CFG_DATA_W-1:0]     cfg_data,
    output efd_pkg::cfg_t                           cfg
);

    efd_pkg::cfg_t cfg_reg;
    efd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                efd_pkg::CFG_START_SYMBOL:  cfg_next.start_symbol = cfg_data[7:0];
                efd_pkg::CFG_TYPE_MASK:     cfg_next.type_mask    = cfg_data[7:0];
                efd_pkg::CFG_PARAM_MASK:    cfg_next.param_mask   = cfg_data[7:0];
                efd_pkg::CFG_TYPE_COUNT:    cfg_next.type_count   = cfg_data[3:0];
                efd_pkg::CFG_PAYLOAD_SIZES: cfg_next.payload_sizes = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_symbol  <= efd_pkg::RST_START_SYMBOL;
            cfg_reg.type_mask     <= efd_pkg::RST_TYPE_MASK;
            cfg_reg.param_mask    <= efd_pkg::RST_PARAM_MASK;
            cfg_reg.type_count    <= efd_pkg::RST_TYPE_COUNT;
            cfg_reg.payload_sizes <= efd_pkg::RST_PAYLOAD_SIZES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/efd_dp.sv */
`default_nettype none

module efd_dp #(
    parameter int MAX_PAYLOAD = 32,
    parameter int MAX_TYPES   = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  efd_pkg::cfg_t                           cfg,
    input  efd_pkg::cmd_t                           cmd,
    output efd_pkg::stat_t                          stat,
    input  wire logic [efd_pkg::BYTE_W-1:0]         rx_byte,
    input  wire logic                               out_stall,
    output logic                                    out_valid,
    output logic [efd_pkg::STATUS_W-1:0]            status,
    output logic [efd_pkg::TYPE_W-1:0]              kind_of_frame,
    output logic [efd_pkg::BYTE_W-1:0]              frame_flags,
    output logic [efd_pkg::BYTE_W-1:0]              payload_byte,
    output logic                                    byte_valid,
    output logic                                    last_of_run
);

    localparam int CW = $clog2(MAX_PAYLOAD + efd_pkg::FRAME_OVERHEAD + 1);
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LW = efd_pkg::BYTE_W + 1;
    localparam logic [CW-1:0] OVF_COUNT = CW'(MAX_PAYLOAD + efd_pkg::FRAME_OVERHEAD);
    localparam logic [efd_pkg::TCNT_W-1:0] TYPE_LIMIT = efd_pkg::TCNT_W'(MAX_TYPES);

    logic [efd_pkg::BYTE_W-1:0]   rx_reg;
    efd_pkg::phase_t              phase_reg, phase_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [efd_pkg::BYTE_W-1:0]   sum_reg, sum_next;
    logic [efd_pkg::BYTE_W-1:0]   len_reg, len_next;
    logic [efd_pkg::TYPE_W-1:0]   type_reg, type_next;
    logic [efd_pkg::BYTE_W-1:0]   flags_reg, flags_next;
    logic [CW-1:0]                rd_cnt_reg;
    logic [efd_pkg::BYTE_W-1:0]   rd_data_reg;
    logic [efd_pkg::BYTE_W-1:0]   mem [MAX_PAYLOAD];

    logic                         out_valid_reg;
    logic [efd_pkg::STATUS_W-1:0] status_reg;
    logic [efd_pkg::TYPE_W-1:0]   kind_reg;
    logic [efd_pkg::BYTE_W-1:0]   flags_out_reg;
    logic [efd_pkg::BYTE_W-1:0]   payload_reg;
    logic                         byte_valid_reg;
    logic                         last_reg;

    logic                         is_start;
    logic                         restart;
    logic                         take;
    logic [CW-1:0]                cnt_new;
    logic [efd_pkg::BYTE_W-1:0]   sum_base;
    logic [efd_pkg::BYTE_W-1:0]   t_masked;
    logic [efd_pkg::TCNT_W-1:0]   limit;
    logic [LW-1:0]                frame_len;
    logic [AW-1:0]                wr_addr;
    logic                         wr_en;
    efd_pkg::act_t                action;
    logic [efd_pkg::STATUS_W-1:0] code;
    logic                         out_free;
    logic                         burst_last;

    // Evaluate the held byte against the frame state
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        len_next   = len_reg;
        type_next  = type_reg;
        flags_next = flags_reg;
        action     = efd_pkg::ACT_NONE;
        code       = efd_pkg::ST_GOOD;
        wr_en      = 1'b0;
        take       = 1'b0;

        is_start  = (rx_reg == cfg.start_symbol);
        restart   = (phase_reg == efd_pkg::PH_START) && !is_start;
        cnt_new   = (restart ? '0 : count_reg) + CW'(1);
        sum_base  = restart ? '0 : sum_reg;
        t_masked  = rx_reg & cfg.type_mask;
        limit     = (cfg.type_count < TYPE_LIMIT) ? cfg.type_count : TYPE_LIMIT;
        frame_len = {1'b0, len_reg} + LW'(efd_pkg::FRAME_OVERHEAD);
        wr_addr   = AW'(cnt_new - CW'(efd_pkg::FRAME_OVERHEAD));

        case (phase_reg)
            efd_pkg::PH_WAIT:
            begin
                if (is_start)
                begin
                    phase_next = efd_pkg::PH_START;
                    count_next = '0;
                    sum_next   = '0;
                end
            end
            efd_pkg::PH_START:
            begin
                take = 1'b1;
            end
            efd_pkg::PH_DATA:
            begin
                if (is_start)
                    phase_next = efd_pkg::PH_START;
                else
                    take = 1'b1;
            end
            default:
            begin
                phase_next = efd_pkg::PH_WAIT;
            end
        endcase

        if (take)
        begin
            phase_next = efd_pkg::PH_DATA;
            count_next = cnt_new;
            sum_next   = sum_base;
            if (cnt_new == CW'(1))
            begin
                // header byte
                type_next  = t_masked[efd_pkg::TYPE_W-1:0];
                flags_next = rx_reg & cfg.param_mask;
                if (t_masked >= {4'b0000, limit})
                begin
                    action     = efd_pkg::ACT_STATUS;
                    code       = efd_pkg::ST_UNKNOWN;
                    phase_next = efd_pkg::PH_WAIT;
                    count_next = '0;
                end
                else
                begin
                    len_next = cfg.payload_sizes[{t_masked[2:0], 3'b000} +: 8];
                    sum_next = rx_reg;
                end
            end
            else if (LW'(cnt_new) == frame_len)
            begin
                // checksum byte
                phase_next = efd_pkg::PH_WAIT;
                count_next = '0;
                if (rx_reg != sum_base)
                begin
                    action = efd_pkg::ACT_STATUS;
                    code   = efd_pkg::ST_CHECKSUM;
                end
                else if (len_reg == '0)
                begin
                    action = efd_pkg::ACT_STATUS;
                    code   = efd_pkg::ST_GOOD;
                end
                else
                begin
                    action = efd_pkg::ACT_BURST;
                end
            end
            else if (cnt_new >= OVF_COUNT)
            begin
                action     = efd_pkg::ACT_STATUS;
                code       = efd_pkg::ST_OVERFLOW;
                phase_next = efd_pkg::PH_WAIT;
                count_next = '0;
            end
            else
            begin
                wr_en    = 1'b1;
                sum_next = sum_base + rx_reg;
            end
        end
    end

    assign out_free   = !out_valid_reg || !out_stall;
    assign burst_last = (LW'(rd_cnt_reg) + LW'(1)) == {1'b0, len_reg};

    assign stat.action     = action;
    assign stat.out_free   = out_free;
    assign stat.burst_last = burst_last;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            rx_reg <= rx_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= efd_pkg::PH_WAIT;
            count_reg <= '0;
            sum_reg   <= '0;
            len_reg   <= '0;
            type_reg  <= '0;
            flags_reg <= '0;
        end
        else if (cmd.commit)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            len_reg   <= len_next;
            type_reg  <= type_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_cnt_reg <= '0;
        else if (cmd.commit && (action == efd_pkg::ACT_BURST))
            rd_cnt_reg <= '0;
        else if (cmd.emit_step)
            rd_cnt_reg <= rd_cnt_reg + CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_en)
            mem[wr_addr] <= rx_reg;
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_cnt_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_status || cmd.emit_step)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_status)
        begin
            status_reg     <= code;
            kind_reg       <= type_next;
            flags_out_reg  <= flags_next;
            payload_reg    <= '0;
            byte_valid_reg <= 1'b0;
            last_reg       <= 1'b1;
        end
        else if (cmd.emit_step)
        begin
            status_reg     <= efd_pkg::ST_GOOD;
            kind_reg       <= type_reg;
            flags_out_reg  <= flags_reg;
            payload_reg    <= rd_data_reg;
            byte_valid_reg <= 1'b1;
            last_reg       <= burst_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign kind_of_frame = kind_reg;
    assign frame_flags   = flags_out_reg;
    assign payload_byte  = payload_reg;
    assign byte_valid    = byte_valid_reg;
    assign last_of_run   = last_reg;

endmodule

`default_nettype wire

/* rtl/efd_ctrl.sv */
`default_nettype none

`include "escaped_frame_decoder_defines.svh"

module efd_ctrl (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  efd_pkg::stat_t stat,
    output efd_pkg::cmd_t  cmd
);

    efd_pkg::ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            efd_pkg::CS_IDLE:
            begin
                if (in_valid)
                    state_next = efd_pkg::CS_EVAL;
            end
            efd_pkg::CS_EVAL:
            begin
                case (stat.action)
                    efd_pkg::ACT_NONE:   state_next = efd_pkg::CS_IDLE;
                    efd_pkg::ACT_STATUS:
                    begin
                        if (stat.out_free)
                            state_next = efd_pkg::CS_IDLE;
                    end
                    efd_pkg::ACT_BURST:  state_next = efd_pkg::CS_EMIT_RD;
                    default:             state_next = efd_pkg::CS_IDLE;
                endcase
            end
            efd_pkg::CS_EMIT_RD:
            begin
                state_next = efd_pkg::CS_EMIT_LD;
            end
            efd_pkg::CS_EMIT_LD:
            begin
                if (stat.out_free)
                    state_next = stat.burst_last ? efd_pkg::CS_IDLE : efd_pkg::CS_EMIT_RD;
            end
            default:
            begin
                state_next = efd_pkg::CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            efd_pkg::CS_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            efd_pkg::CS_EVAL:
            begin
                case (stat.action)
                    efd_pkg::ACT_NONE:   cmd.commit = 1'b1;
                    efd_pkg::ACT_STATUS:
                    begin
                        cmd.commit      = stat.out_free;
                        cmd.load_status = stat.out_free;
                    end
                    efd_pkg::ACT_BURST:  cmd.commit = 1'b1;
                    default:             cmd.commit = 1'b1;
                endcase
            end
            efd_pkg::CS_EMIT_RD:
            begin
                cmd = '0;
            end
            efd_pkg::CS_EMIT_LD:
            begin
                cmd.emit_step = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= efd_pkg::CS_IDLE;
        else
            state_reg <= state_next;
    end

    `EFD_ASSERT_NEXT(a_accept_then_eval, (state_reg == efd_pkg::CS_IDLE) && in_valid, state_reg == efd_pkg::CS_EVAL, "accepted word not evaluated next cycle")
    `EFD_ASSERT_IMPL(a_status_needs_room, cmd.load_status, stat.out_free && cmd.commit, "status loaded into a busy output register")
    `EFD_ASSERT_IMPL(a_emit_needs_room, cmd.emit_step, stat.out_free, "payload word loaded into a busy output register")
    `EFD_ASSERT_NEXT(a_read_then_load, state_reg == efd_pkg::CS_EMIT_RD, state_reg == efd_pkg::CS_EMIT_LD, "store read not followed by load")

endmodule

`default_nettype wire

/* rtl/escaped_frame_decoder.sv */
// Byte-stuffed frame receiver: each rx_byte word is accepted, then evaluated.
// A status result is loaded into the output register when it has room.
// After its checksum byte, a good frame's payload streams from the payload store,
// each word read, then loaded once the output has room; input stalls meanwhile.
// rst_n clears the configuration registers, frame state and output valid at
// once; the payload store is not cleared and needs no clearing pass.
`default_nettype none

module escaped_frame_decoder #(
    parameter int MAX_PAYLOAD = 32,
    parameter int MAX_TYPES   = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration write port
    input  wire logic                               cfg_we,
    input  wire logic [efd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [efd_pkg::CFG_DATA_W-1:0]     cfg_data,
    // received byte channel
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [efd_pkg::BYTE_W-1:0]         rx_byte,
    // result channel
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [efd_pkg::STATUS_W-1:0]            status,
    output logic [efd_pkg::TYPE_W-1:0]              kind_of_frame,
    output logic [efd_pkg::BYTE_W-1:0]              frame_flags,
    output logic [efd_pkg::BYTE_W-1:0]              payload_byte,
    output logic                                    byte_valid,
    output logic                                    last_of_run
);

    efd_pkg::cfg_t  cfg;
    efd_pkg::cmd_t  cmd;
    efd_pkg::stat_t stat;

    // Register file: start symbol, masks, type count and per-type lengths.
    efd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer: accept a word, evaluate it, then drain a payload burst from
    // the store one word at a time while the output register has room.
    efd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Frame state, checksum, payload store and the output register. The
    // output register lets the next byte enter while a result waits.
    efd_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .MAX_TYPES   (MAX_TYPES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .stat          (stat),
        .rx_byte       (rx_byte),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .status        (status),
        .kind_of_frame (kind_of_frame),
        .frame_flags   (frame_flags),
        .payload_byte  (payload_byte),
        .byte_valid    (byte_valid),
        .last_of_run   (last_of_run)
    );

endmodule

`default_nettype wire

/* test/escaped_frame_decoder_tb.sv */
`timescale 1ns / 1ps

module escaped_frame_decoder_tb;
    import efd_pkg::*;

    localparam int MAX_PAYLOAD   = 32;
    localparam int MAX_TYPES     = 8;
    // Cycles to let a word that causes no result finish its evaluate pass.
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    // Long receiver hold-off used to back the block up into its input.
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_WORDS  = 37;
    localparam longint LIMIT_NS  = 3_000_000;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [TYPE_W-1:0]   kind;
        logic [BYTE_W-1:0]   flags;
        logic [BYTE_W-1:0]   pbyte;
        logic                bvalid;
        logic                last;
    } frame_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [BYTE_W-1:0]     rx_byte   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [TYPE_W-1:0]     kind_of_frame;
    logic [BYTE_W-1:0]     frame_flags;
    logic [BYTE_W-1:0]     payload_byte;
    logic                  byte_valid;
    logic                  last_of_run;

    // Shadow of the register file, updated on every write.
    cfg_t reg_shadow;

    // Decoder state as the testbench tracks it.
    phase_t          rx_phase;
    int unsigned     frame_count;
    int unsigned     frame_len;
    logic [7:0]      sum_acc;
    logic [2:0]      cur_type;
    logic [7:0]      cur_flags;
    logic [7:0]      payload_copy [0:MAX_PAYLOAD-1];

    frame_result_t   pending_results [$];

    int              error_count    = 0;
    int unsigned     sent_bytes     = 0;
    int              send_gap_pct   = 0;
    int              recv_stall_pct = 0;
    logic            hold_request   = 1'b0;
    int              hold_left      = 0;

    escaped_frame_decoder #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .MAX_TYPES   (MAX_TYPES)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .kind_of_frame (kind_of_frame),
        .frame_flags   (frame_flags),
        .payload_byte  (payload_byte),
        .byte_valid    (byte_valid),
        .last_of_run   (last_of_run)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void queue_result(input logic [STATUS_W-1:0] st, input logic [7:0] pb,
                                         input logic bv, input logic lst);
        frame_result_t r;
        r.status = st;
        r.kind   = cur_type;
        r.flags  = cur_flags;
        r.pbyte  = pb;
        r.bvalid = bv;
        r.last   = lst;
        pending_results.push_back(r);
    endfunction

    function automatic bit type_ok(input logic [7:0] hdr);
        int unsigned t;
        int unsigned lim;
        t   = hdr & reg_shadow.type_mask;
        lim = (reg_shadow.type_count < MAX_TYPES) ? reg_shadow.type_count : MAX_TYPES;
        return t < lim;
    endfunction

    // Take one unescaped frame word: header, payload or checksum.
    function automatic void absorb_frame_byte(input logic [7:0] d);
        int unsigned t;
        int unsigned n;
        int unsigned idx;
        frame_count++;
        if (frame_count == 1)
        begin
            t         = d & reg_shadow.type_mask;
            cur_type  = t[2:0];
            cur_flags = d & reg_shadow.param_mask;
            if (!type_ok(d))
            begin
                queue_result(ST_UNKNOWN, 8'h00, 1'b0, 1'b1);
                rx_phase    = PH_WAIT;
                frame_count = 0;
            end
            else
            begin
                frame_len = reg_shadow.payload_sizes[8*t +: 8] + FRAME_OVERHEAD;
                sum_acc   = d;
            end
        end
        else if (frame_count == frame_len)
        begin
            n = frame_len - FRAME_OVERHEAD;
            if (d != sum_acc)
                queue_result(ST_CHECKSUM, 8'h00, 1'b0, 1'b1);
            else if (n == 0)
                queue_result(ST_GOOD, 8'h00, 1'b0, 1'b1);
            else
                for (idx = 0; idx < n; idx++)
                    queue_result(ST_GOOD, payload_copy[idx], 1'b1, idx + 1 == n);
            rx_phase    = PH_WAIT;
            frame_count = 0;
        end
        else
        begin
            idx = frame_count - FRAME_OVERHEAD;
            if (idx >= MAX_PAYLOAD)
            begin
                queue_result(ST_OVERFLOW, 8'h00, 1'b0, 1'b1);
                rx_phase    = PH_WAIT;
                frame_count = 0;
            end
            else
            begin
                payload_copy[idx] = d;
                sum_acc           = sum_acc + d;
            end
        end
    endfunction

    // Advance the tracked decoder by one accepted rx word.
    function automatic void decode_rx_byte(input logic [7:0] d);
        case (rx_phase)
            PH_WAIT:
                if (d == reg_shadow.start_symbol)
                begin
                    rx_phase    = PH_START;
                    frame_count = 0;
                    sum_acc     = 8'h00;
                end
            PH_START:
            begin
                // A start symbol followed by anything else restarts the frame.
                if (d != reg_shadow.start_symbol)
                begin
                    frame_count = 0;
                    sum_acc     = 8'h00;
                end
                rx_phase = PH_DATA;
                absorb_frame_byte(d);
            end
            default:
                if (d == reg_shadow.start_symbol)
                    rx_phase = PH_START;
                else
                    absorb_frame_byte(d);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        if (error_count < 30)
            $display("mismatch at %0t ns: %s", $time, what);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Compare each accepted result word with the oldest expectation.
    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result word with nothing pending");
            else
            begin
                want = pending_results.pop_front();
                check_field("status", status, want.status);
                check_field("kind_of_frame", kind_of_frame, want.kind);
                check_field("frame_flags", frame_flags, want.flags);
                check_field("payload_byte", payload_byte, want.pbyte);
                check_field("byte_valid", byte_valid, want.bvalid);
                check_field("last_of_run", last_of_run, want.last);
            end
        end
    end

    // Receiver: random stall, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request <= 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one rx word, with random idle cycles first; hold it until taken.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_rx_byte(b);
        sent_bytes++;
    endtask

    // Send one frame data word, doubling it when it matches the start symbol.
    task automatic send_data(input logic [7:0] b);
        send_byte(b);
        if (b == reg_shadow.start_symbol)
            send_byte(b);
    endtask

    // Send a whole frame for the current settings. Stop after the word that
    // overflows the store, and after the header for an unknown type.
    task automatic send_frame(input logic [7:0] hdr, input int esc_pct, input bit bad_sum);
        int unsigned t;
        int unsigned len;
        int unsigned i;
        logic [7:0]  sum;
        logic [7:0]  b;
        t = hdr & reg_shadow.type_mask;
        send_byte(reg_shadow.start_symbol);
        send_data(hdr);
        if (type_ok(hdr))
        begin
            len = reg_shadow.payload_sizes[8*t +: 8];
            sum = hdr;
            for (i = 0; i < len && i <= MAX_PAYLOAD; i++)
            begin
                if ($urandom_range(99) < esc_pct)
                    b = reg_shadow.start_symbol;
                else
                    b = $urandom_range(255);
                send_data(b);
                sum = sum + b;
            end
            if (len <= MAX_PAYLOAD)
                send_data(bad_sum ? sum ^ (8'h01 << $urandom_range(7)) : sum);
        end
    endtask

    // Drop valid and wait until every predicted word has come out.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_START_SYMBOL:  reg_shadow.start_symbol  = val[7:0];
            CFG_TYPE_MASK:     reg_shadow.type_mask     = val[7:0];
            CFG_PARAM_MASK:    reg_shadow.param_mask    = val[7:0];
            CFG_TYPE_COUNT:    reg_shadow.type_count    = val[3:0];
            CFG_PAYLOAD_SIZES: reg_shadow.payload_sizes = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_all(input logic [7:0] start, input logic [7:0] tmask,
                             input logic [7:0] pmask, input logic [3:0] tcount,
                             input logic [63:0] sizes);
        write_reg(CFG_START_SYMBOL, start);
        write_reg(CFG_TYPE_MASK, tmask);
        write_reg(CFG_PARAM_MASK, pmask);
        write_reg(CFG_TYPE_COUNT, tcount);
        write_reg(CFG_PAYLOAD_SIZES, sizes);
    endtask

    // Header with a supported type where a few tries find one.
    function automatic logic [7:0] pick_header();
        logic [7:0] h;
        int         tries;
        h = $urandom_range(255);
        for (tries = 0; tries < 12 && !type_ok(h); tries++)
            h = $urandom_range(255);
        return h;
    endfunction

    // Mostly short lengths, now and then a full store or an overflow.
    task automatic load_random_settings();
        logic [63:0] sizes;
        logic [7:0]  tmask;
        int          k;
        for (k = 0; k < 8; k++)
            case ($urandom_range(15))
                0:       sizes[8*k +: 8] = MAX_PAYLOAD;
                1:       sizes[8*k +: 8] = MAX_PAYLOAD + 1;
                2:       sizes[8*k +: 8] = 8'hFF;
                default: sizes[8*k +: 8] = $urandom_range(5);
            endcase
        case ($urandom_range(3))
            0:       tmask = 8'h07;
            1:       tmask = 8'h03;
            2:       tmask = 8'h0E;
            default: tmask = $urandom_range(255);
        endcase
        write_all($urandom_range(255), tmask, ($urandom_range(1) != 0) ? ~tmask :
                  8'($urandom_range(255)), $urandom_range(2, 15), sizes);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: every type is known and every payload is empty.
    task automatic test_reset_settings();
        send_frame(8'h00, 0, 1'b0);
        send_frame(8'hFF, 0, 1'b0);
        // header equal to the start symbol goes out doubled
        send_frame(RST_START_SYMBOL, 0, 1'b0);
        send_frame(8'h35, 0, 1'b1);
        wait_for_results();
    endtask

    // Good frames, escapes, checksum error, unknown types, restart, overflow.
    task automatic test_frame_cases();
        write_all(8'hA5, 8'h07, 8'hF8, 4'd6, {8'd2, 8'd2, 8'd255, 8'd33, 8'd32, 8'd3, 8'd1, 8'd0});
        send_frame(8'h01, 0, 1'b0);
        send_frame(8'hA2, 50, 1'b0);
        send_frame(8'h09, 0, 1'b1);
        send_frame(8'h06, 0, 1'b0);
        send_frame(8'hFF, 0, 1'b0);
        // drop a partial frame by opening a new one
        send_byte(8'hA5);
        send_data(8'h02);
        send_data(8'h11);
        send_frame(8'h11, 0, 1'b0);
        // header equal to the start symbol, type with a too long payload
        send_frame(8'hA5, 10, 1'b0);
        send_frame(8'h00, 0, 1'b0);
        wait_for_results();
    endtask

    // Masks, symbols and counts at their extremes.
    task automatic test_register_extremes();
        write_all(8'h00, 8'hFF, 8'h00, 4'd15, 64'h0706_0504_0302_0100);
        send_frame(8'h00, 0, 1'b0);
        send_frame(8'h05, 30, 1'b0);
        send_frame(8'h80, 0, 1'b0);
        send_frame(8'hFF, 0, 1'b0);
        wait_for_results();
        write_all(8'hFF, 8'h00, 8'hFF, 4'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_frame(8'hFF, 10, 1'b0);
        send_frame(8'h5A, 0, 1'b0);
        wait_for_results();
        write_reg(CFG_TYPE_COUNT, 4'd0);
        send_frame(8'h00, 0, 1'b0);
        wait_for_results();
    endtask

    // Hold the receiver off while full-size frames keep coming, so the
    // block backs up into its input; then let it drain completely.
    task automatic test_backpressure();
        write_all(RST_START_SYMBOL, RST_TYPE_MASK, RST_PARAM_MASK, RST_TYPE_COUNT,
                  64'h2020_2020_2020_2020);
        send_gap_pct = 0;
        hold_request <= 1'b1;
        repeat (3) send_frame($urandom_range(255), 5, 1'b0);
        wait_for_results();
    endtask

    // Mostly well-formed frames with random content, plus broken ones.
    task automatic run_random_phase(input int gap_pct, input int stall_pct);
        int unsigned first;
        int          pick;
        int          k;
        send_gap_pct = gap_pct;
        recv_stall_pct <= stall_pct;
        load_random_settings();
        first = sent_bytes;
        while (sent_bytes - first < RANDOM_WORDS)
        begin
            pick = $urandom_range(99);
            if (pick < 62)
                send_frame(pick_header(), 8, 1'b0);
            else if (pick < 72)
                send_frame(pick_header(), 8, 1'b1);
            else if (pick < 80)
                send_frame($urandom_range(255), 8, 1'b0);
            else if (pick < 90)
            begin
                // truncated frame: the next start symbol abandons it
                send_byte(reg_shadow.start_symbol);
                send_data(pick_header());
                for (k = $urandom_range(3); k > 0; k--)
                    send_data($urandom_range(255));
            end
            else if (pick < 96)
                send_byte($urandom_range(255));
            else
                wait_for_results();
        end
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        run_random_phase(32, 65);
        run_random_phase(65, 32);
        run_random_phase(0, 0);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        reg_shadow  = {RST_START_SYMBOL, RST_TYPE_MASK, RST_PARAM_MASK, RST_TYPE_COUNT,
                       RST_PAYLOAD_SIZES};
        rx_phase    = PH_WAIT;
        frame_count = 0;
        frame_len   = 0;
        sum_acc     = 8'h00;
        cur_type    = 3'd0;
        cur_flags   = 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct = 32;
        recv_stall_pct <= 65;
        test_reset_settings();
        test_frame_cases();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Stop a hung run.
    initial
    begin
        #(LIMIT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
